// ===== src/tta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_pkg
// Shared types, constants and small arithmetic helpers for the temperature
// threshold alarm.
// ----------------------------------------------------------------------------
package tta_pkg;

  localparam int unsigned OpW      = 2;
  localparam int unsigned RawW     = 12;
  localparam int unsigned StepW    = 10;
  localparam int unsigned MagW     = 14;   // |centidegrees| up to 12800
  localparam int unsigned ThrW     = 14;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned DigitW   = 4;

  localparam logic [ThrW-1:0]  ThrMax    = 14'd9900;
  localparam logic [ThrW-1:0]  HighReset = 14'd3000;
  localparam logic [ThrW-1:0]  LowReset  = 14'd1000;
  localparam logic [StepW-1:0] StepReset = 10'd100;

  typedef enum logic [OpW-1:0] {
    OP_SAMPLE = 2'd0,
    OP_MODE   = 2'd1,
    OP_UP     = 2'd2,
    OP_DOWN   = 2'd3
  } op_e;

  typedef enum logic [ModeW-1:0] {
    MODE_NONE = 2'd0,
    MODE_HIGH = 2'd1,
    MODE_LOW  = 2'd2
  } mode_e;

  // State handed from the update stage to the readout stage
  typedef struct packed {
    logic              valid;
    logic              neg;
    logic [MagW-1:0]   mag;
    logic [ThrW-1:0]   high;
    logic [ThrW-1:0]   low;
    logic [ModeW-1:0]  mode;
  } state_t;

  typedef struct packed {
    logic [DigitW-1:0] tens;
    logic [DigitW-1:0] units;
  } bcd2_t;

  // v / 100 by reciprocal: exact for v < 43690
  function automatic logic [7:0] div100(input logic [MagW-1:0] v);
    logic [26:0] prod;
    prod = {13'd0, v} * 27'd5243;
    return prod[26:19];
  endfunction

  // Split 0..99 into two decimal digits; v * 205 >> 11 is exact below 1024
  function automatic bcd2_t split10(input logic [6:0] v);
    logic [17:0] prod;
    logic [3:0]  t;
    logic [6:0]  u;
    bcd2_t       r;
    prod    = {11'd0, v} * 18'd205;
    t       = prod[14:11];
    u       = v - ({3'd0, t} * 7'd10);
    r.tens  = t;
    r.units = u[3:0];
    return r;
  endfunction

endpackage

// ===== src/tta_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_in_if
// Input channel: valid/ready handshake with op code and raw sensor reading.
// ----------------------------------------------------------------------------
interface tta_in_if;
  logic                          valid;
  logic                          ready;
  logic [tta_pkg::OpW-1:0]       op;
  logic signed [tta_pkg::RawW-1:0] raw_sample;

  modport source (output valid, output op, output raw_sample, input ready);
  modport sink   (input valid, input op, input raw_sample, output ready);
endinterface

// ===== src/tta_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_out_if
// Result channel: valid/ready handshake with alarm, sign and readout digits.
// ----------------------------------------------------------------------------
interface tta_out_if;
  logic                          valid;
  logic                          ready;
  logic                          alarm;
  logic                          negative;
  logic [tta_pkg::DigitW-1:0]    digit_hundreds;
  logic [tta_pkg::DigitW-1:0]    digit_tens;
  logic [tta_pkg::DigitW-1:0]    digit_units;
  logic [tta_pkg::DigitW-1:0]    digit_tenths;
  logic [tta_pkg::DigitW-1:0]    digit_hundredths;
  logic [tta_pkg::DigitW-1:0]    high_tens;
  logic [tta_pkg::DigitW-1:0]    high_units;
  logic [tta_pkg::DigitW-1:0]    low_tens;
  logic [tta_pkg::DigitW-1:0]    low_units;
  logic [tta_pkg::ModeW-1:0]     adjust_mode;

  modport source (
    output valid, output alarm, output negative,
    output digit_hundreds, output digit_tens, output digit_units,
    output digit_tenths, output digit_hundredths,
    output high_tens, output high_units, output low_tens, output low_units,
    output adjust_mode, input ready
  );
  modport sink (
    input valid, input alarm, input negative,
    input digit_hundreds, input digit_tens, input digit_units,
    input digit_tenths, input digit_hundredths,
    input high_tens, input high_units, input low_tens, input low_units,
    input adjust_mode, output ready
  );
endinterface

// ===== src/tta_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_update
// Takes input transfers, converts readings to centidegrees and applies key
// events to the mode and thresholds.
// ----------------------------------------------------------------------------
module tta_update (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tta_in_if.sink                      in_i,
  input  logic                        threshold_step_we_i,
  input  logic [tta_pkg::StepW-1:0]   threshold_step_i,
  input  logic                        advance_i,
  output tta_pkg::state_t             state_o
);

  logic                        valid_q, valid_d;
  logic                        neg_q, neg_d;
  logic [tta_pkg::MagW-1:0]    mag_q, mag_d;
  logic [tta_pkg::ThrW-1:0]    high_q, high_d;
  logic [tta_pkg::ThrW-1:0]    low_q, low_d;
  logic [tta_pkg::ModeW-1:0]   mode_q, mode_d;
  logic [tta_pkg::StepW-1:0]   step_q;

  logic                        accept;
  logic [tta_pkg::RawW-1:0]    raw_abs;
  logic [15:0]                 scaled;
  logic [tta_pkg::ThrW-1:0]    sel_thr, thr_up, thr_dn;
  logic [tta_pkg::ThrW:0]      thr_sum;

  assign in_i.ready = !valid_q || advance_i;
  assign accept     = in_i.valid && in_i.ready;

  // |raw| * 25 + 2, then drop two bits; -2048 reads as 2048 unsigned
  assign raw_abs = in_i.raw_sample[tta_pkg::RawW-1] ? (~in_i.raw_sample + 1'b1)
                                                    : in_i.raw_sample;
  assign scaled  = ({4'd0, raw_abs} << 4) + ({4'd0, raw_abs} << 3)
                 + {4'd0, raw_abs} + 16'd2;

  assign sel_thr = (mode_q == tta_pkg::MODE_HIGH) ? high_q : low_q;
  assign thr_sum = {1'b0, sel_thr} + {5'd0, step_q};
  assign thr_up  = (thr_sum > {1'b0, tta_pkg::ThrMax}) ? tta_pkg::ThrMax
                                                      : thr_sum[tta_pkg::ThrW-1:0];
  assign thr_dn  = (sel_thr > {4'd0, step_q}) ? (sel_thr - {4'd0, step_q})
                                              : '0;

  always_comb begin
    valid_d = valid_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    high_d  = high_q;
    low_d   = low_q;
    mode_d  = mode_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      case (in_i.op)
        tta_pkg::OP_SAMPLE: begin
          neg_d = in_i.raw_sample[tta_pkg::RawW-1];
          mag_d = scaled[15:2];
        end
        tta_pkg::OP_MODE: begin
          mode_d = (mode_q >= tta_pkg::MODE_LOW) ? tta_pkg::MODE_NONE
                                                 : mode_q + 1'b1;
        end
        tta_pkg::OP_UP, tta_pkg::OP_DOWN: begin
          if (mode_q == tta_pkg::MODE_HIGH) begin
            high_d = (in_i.op == tta_pkg::OP_UP) ? thr_up : thr_dn;
          end else if (mode_q == tta_pkg::MODE_LOW) begin
            low_d = (in_i.op == tta_pkg::OP_UP) ? thr_up : thr_dn;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      high_q  <= tta_pkg::HighReset;
      low_q   <= tta_pkg::LowReset;
      mode_q  <= tta_pkg::MODE_NONE;
      step_q  <= tta_pkg::StepReset;
    end else begin
      valid_q <= valid_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
      high_q  <= high_d;
      low_q   <= low_d;
      mode_q  <= mode_d;
      if (threshold_step_we_i) begin
        step_q <= threshold_step_i;
      end
    end
  end

  assign state_o.valid = valid_q;
  assign state_o.neg   = neg_q;
  assign state_o.mag   = mag_q;
  assign state_o.high  = high_q;
  assign state_o.low   = low_q;
  assign state_o.mode  = mode_q;

endmodule

// ===== src/tta_readout.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_readout
// Derives alarm and decimal readouts from the updated state and holds them
// in the result register.
// ----------------------------------------------------------------------------
module tta_readout (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tta_pkg::state_t  state_i,
  output logic             advance_o,
  tta_out_if.source        out_o
);

  logic        valid_q;
  logic [7:0]  mag_q100, high_q100, low_q100;
  logic [13:0] mag_rem;
  logic        hund;
  logic [6:0]  mag_hi;
  tta_pkg::bcd2_t mag_int, mag_frac, high_bcd, low_bcd;
  logic        alarm_d;

  logic        alarm_q, neg_q;
  logic [3:0]  d_hund_q, d_tens_q, d_units_q, d_tenths_q, d_hths_q;
  logic [3:0]  h_tens_q, h_units_q, l_tens_q, l_units_q;
  logic [1:0]  mode_q;

  assign advance_o = !valid_q || out_o.ready;

  assign mag_q100  = tta_pkg::div100(state_i.mag);
  assign mag_rem   = state_i.mag - ({6'd0, mag_q100} * 14'd100);
  assign hund      = (mag_q100 >= 8'd100);
  assign mag_hi    = hund ? (mag_q100[6:0] - 7'd100) : mag_q100[6:0];
  assign mag_int   = tta_pkg::split10(mag_hi);
  assign mag_frac  = tta_pkg::split10(mag_rem[6:0]);
  assign high_q100 = tta_pkg::div100(state_i.high);
  assign low_q100  = tta_pkg::div100(state_i.low);
  assign high_bcd  = tta_pkg::split10(high_q100[6:0]);
  assign low_bcd   = tta_pkg::split10(low_q100[6:0]);

  // negative reading is always at or below a non-negative low threshold
  assign alarm_d = state_i.neg || (state_i.mag >= state_i.high)
                 || (state_i.mag <= state_i.low);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= state_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && state_i.valid) begin
      alarm_q    <= alarm_d;
      neg_q      <= state_i.neg;
      d_hund_q   <= {3'd0, hund};
      d_tens_q   <= mag_int.tens;
      d_units_q  <= mag_int.units;
      d_tenths_q <= mag_frac.tens;
      d_hths_q   <= mag_frac.units;
      h_tens_q   <= high_bcd.tens;
      h_units_q  <= high_bcd.units;
      l_tens_q   <= low_bcd.tens;
      l_units_q  <= low_bcd.units;
      mode_q     <= state_i.mode;
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.alarm            = alarm_q;
  assign out_o.negative         = neg_q;
  assign out_o.digit_hundreds   = d_hund_q;
  assign out_o.digit_tens       = d_tens_q;
  assign out_o.digit_units      = d_units_q;
  assign out_o.digit_tenths     = d_tenths_q;
  assign out_o.digit_hundredths = d_hths_q;
  assign out_o.high_tens        = h_tens_q;
  assign out_o.high_units       = h_units_q;
  assign out_o.low_tens         = l_tens_q;
  assign out_o.low_units        = l_units_q;
  assign out_o.adjust_mode      = mode_q;

endmodule

// ===== src/temperature_threshold_alarm_core.sv =====
`timescale 1ns / 1ps
// A transfer moves through the update register into the result register.
// Throughput: one item per cycle unless the output stalls; the two registers
// form a two-stage pipeline that advances while the result register is free.
// Reset: pipeline empty, reading 0, high 30.00, low 10.00 degrees,
// step 1.00 degree, no adjust mode.
// ----------------------------------------------------------------------------
// temperature_threshold_alarm_core
// Temperature alarm with key-adjustable high and low thresholds.
// ----------------------------------------------------------------------------
module temperature_threshold_alarm_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tta_in_if.sink                      in_i,
  tta_out_if.source                   out_o,
  input  logic                        threshold_step_we_i,
  input  logic [tta_pkg::StepW-1:0]   threshold_step_i
);

  // Stage 1 holds the block state after each transfer; its valid flag
  // marks a result not yet moved into the result register.
  tta_pkg::state_t state;
  logic            advance;

  // Sample conversion (|raw|*25+2 >> 2) and threshold stepping with
  // saturation at 0 and 99.00 degrees live here, as does the step register.
  tta_update u_update (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_i                (in_i),
    .threshold_step_we_i (threshold_step_we_i),
    .threshold_step_i    (threshold_step_i),
    .advance_i           (advance),
    .state_o             (state)
  );

  // Stage 2: decimal split by reciprocal multiply and small digit splits,
  // alarm compare, result register. A stall here holds stage 1 in turn;
  // a free or draining result register lets a new transfer in every cycle.
  tta_readout u_readout (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .state_i   (state),
    .advance_o (advance),
    .out_o     (out_o)
  );

endmodule

// ===== src/tta_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_checker
// Port-level checks on the temperature alarm, bound to the top level.
// ----------------------------------------------------------------------------
module tta_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       alarm,
  input logic       negative,
  input logic [3:0] digit_hundreds,
  input logic [3:0] digit_tens,
  input logic [3:0] digit_tenths,
  input logic [3:0] high_tens,
  input logic [3:0] low_tens
);

  // a free or draining result register never blocks the input
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with room in the result register");

  a_neg_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && negative) |-> alarm)
    else $error("sub-zero reading without alarm");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (digit_hundreds <= 4'd1 && digit_tens <= 4'd9
                   && digit_tenths <= 4'd9 && high_tens <= 4'd9 && low_tens <= 4'd9))
    else $error("readout digit out of range");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind temperature_threshold_alarm_core tta_checker u_tta_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready       (in_i.ready),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .alarm          (out_o.alarm),
  .negative       (out_o.negative),
  .digit_hundreds (out_o.digit_hundreds),
  .digit_tens     (out_o.digit_tens),
  .digit_tenths   (out_o.digit_tenths),
  .high_tens      (out_o.high_tens),
  .low_tens       (out_o.low_tens)
);

// ===== dv/tta_alarm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_alarm_checker
// Watches both channels of the temperature alarm core and the threshold step
// write port. Keeps its own copy of the reading, the thresholds, the adjust
// mode and the step, predicts the readout for every input transfer and
// compares every result transfer with the oldest readout still due.
// ----------------------------------------------------------------------------
module tta_alarm_checker
  import tta_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  tta_in_if                in_mon,
  tta_out_if               out_mon,
  input  logic             step_we_i,
  input  logic [StepW-1:0] step_i,
  output int               errors_o,
  output int               pending_o,
  output int               results_o
);

  typedef struct packed {
    logic              alarm;
    logic              negative;
    logic [DigitW-1:0] digit_hundreds;
    logic [DigitW-1:0] digit_tens;
    logic [DigitW-1:0] digit_units;
    logic [DigitW-1:0] digit_tenths;
    logic [DigitW-1:0] digit_hundredths;
    logic [DigitW-1:0] high_tens;
    logic [DigitW-1:0] high_units;
    logic [DigitW-1:0] low_tens;
    logic [DigitW-1:0] low_units;
    logic [ModeW-1:0]  adjust_mode;
  } readout_t;

  // Alarm state, all in centidegrees
  int       step_cd;
  int       reading_cd;
  int       high_cd;
  int       low_cd;
  mode_e    mode_q;
  readout_t readouts_due[$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns  MISMATCH  result %0d: %s", $time, results_o, msg);
    errors_o++;
  endtask

  task automatic check_field(input string name, input logic [3:0] got,
                             input logic [3:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  function automatic int raise_threshold(input int thr);
    return (thr + step_cd > int'(ThrMax)) ? int'(ThrMax) : thr + step_cd;
  endfunction

  function automatic int lower_threshold(input int thr);
    return (thr > step_cd) ? thr - step_cd : 0;
  endfunction

  // Updates the alarm state for one transfer and returns the readout after it
  function automatic readout_t predict_readout(input op_e op,
                                               input logic signed [RawW-1:0] raw);
    readout_t r;
    int       mag;
    case (op)
      OP_SAMPLE: begin
        // 1/16 degree to centidegrees, half up on the magnitude
        mag        = (raw < 0) ? -int'(raw) : int'(raw);
        mag        = (mag * 25 + 2) / 4;
        reading_cd = (raw < 0) ? -mag : mag;
      end
      OP_MODE: begin
        case (mode_q)
          MODE_NONE: mode_q = MODE_HIGH;
          MODE_HIGH: mode_q = MODE_LOW;
          default:   mode_q = MODE_NONE;
        endcase
      end
      OP_UP: begin
        if (mode_q == MODE_HIGH) high_cd = raise_threshold(high_cd);
        else if (mode_q == MODE_LOW) low_cd = raise_threshold(low_cd);
      end
      default: begin
        if (mode_q == MODE_HIGH) high_cd = lower_threshold(high_cd);
        else if (mode_q == MODE_LOW) low_cd = lower_threshold(low_cd);
      end
    endcase
    mag                = (reading_cd < 0) ? -reading_cd : reading_cd;
    r.alarm            = (reading_cd >= high_cd) || (reading_cd <= low_cd);
    r.negative         = (reading_cd < 0);
    r.digit_hundreds   = 4'(mag / 10000);
    r.digit_tens       = 4'(mag % 10000 / 1000);
    r.digit_units      = 4'(mag % 1000 / 100);
    r.digit_tenths     = 4'(mag % 100 / 10);
    r.digit_hundredths = 4'(mag % 10);
    r.high_tens        = 4'(high_cd / 1000);
    r.high_units       = 4'(high_cd % 1000 / 100);
    r.low_tens         = 4'(low_cd / 1000);
    r.low_units        = 4'(low_cd % 1000 / 100);
    r.adjust_mode      = mode_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    readout_t due;
    if (!rst_ni) begin
      step_cd    = int'(StepReset);
      reading_cd = 0;
      high_cd    = int'(HighReset);
      low_cd     = int'(LowReset);
      mode_q     = MODE_NONE;
      readouts_due.delete();
      errors_o   = 0;
      results_o  = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        results_o++;
        if (readouts_due.size() == 0) begin
          report_mismatch("result transfer with no readout due");
        end else begin
          due = readouts_due.pop_front();
          check_field("alarm", 4'(out_mon.alarm), 4'(due.alarm));
          check_field("negative", 4'(out_mon.negative), 4'(due.negative));
          check_field("digit_hundreds", out_mon.digit_hundreds, due.digit_hundreds);
          check_field("digit_tens", out_mon.digit_tens, due.digit_tens);
          check_field("digit_units", out_mon.digit_units, due.digit_units);
          check_field("digit_tenths", out_mon.digit_tenths, due.digit_tenths);
          check_field("digit_hundredths", out_mon.digit_hundredths,
                      due.digit_hundredths);
          check_field("high_tens", out_mon.high_tens, due.high_tens);
          check_field("high_units", out_mon.high_units, due.high_units);
          check_field("low_tens", out_mon.low_tens, due.low_tens);
          check_field("low_units", out_mon.low_units, due.low_units);
          check_field("adjust_mode", 4'(out_mon.adjust_mode), 4'(due.adjust_mode));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        readouts_due.push_back(predict_readout(op_e'(in_mon.op), in_mon.raw_sample));
      end
      if (step_we_i) step_cd = int'(step_i);
    end
    pending_o = readouts_due.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the temperature threshold alarm core. A short
// directed run covers reading extremes, alarm boundaries and every key; then
// random readings and key events run under several threshold steps, with
// random idling on both channels and one long output hold-off. All checking
// is done by tta_alarm_checker beside the core.
// ----------------------------------------------------------------------------
module tb;
  import tta_pkg::*;

  localparam int ClkHalf     = 2;
  localparam int ResetCycles = 11;
  localparam int TailCycles  = 8;        // settle time after the last readout
  localparam int LongHold    = 300;      // output hold-off, enough to back up the core
  localparam int CycleLimit  = 1_000_000;
  localparam int PhaseItems  = 125;
  localparam int NumPhases   = 6;

  // Steps per random phase: extremes of the register first, the last one is
  // replaced by a random value at run time
  localparam logic [StepW-1:0] PhaseSteps [NumPhases] =
    '{10'd1000, 10'd1, 10'd0, 10'd1023, 10'd100, 10'd100};

  logic             clk_i;
  logic             rst_ni;
  logic             step_we;
  logic [StepW-1:0] step_data;

  tta_in_if  in_ch ();
  tta_out_if out_ch ();

  int errors;
  int pending;
  int results;
  int transfers_in;
  int step_writes;
  int cycle_count;
  int holds_requested;
  int holds_served;
  bit gaps_on;

  temperature_threshold_alarm_core dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_i                (in_ch),
    .out_o               (out_ch),
    .threshold_step_we_i (step_we),
    .threshold_step_i    (step_data)
  );

  tta_alarm_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .step_we_i (step_we),
    .step_i    (step_data),
    .errors_o  (errors),
    .pending_o (pending),
    .results_o (results)
  );

  // --------------------------------------------------------------------------
  // Clock, reset and watchdog
  // --------------------------------------------------------------------------
  always begin
    clk_i = 1'b0;
    #(ClkHalf);
    clk_i = 1'b1;
    #(ClkHalf);
  end

  initial begin
    rst_ni = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial cycle_count = 0;
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Generous: the slowest legal run is well under a tenth of this
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timed out after %0d cycles with %0d results outstanding",
             CycleLimit, pending);
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Idle lengths: mostly none or short, now and then a long one
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random ready, steady stretches, and the long hold-off when
  // the stimulus asks for one. The hold is counted here, not by the sender.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int len;
    out_ch.ready = 1'b0;
    holds_served = 0;
    forever begin
      if (holds_requested != holds_served) begin
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        holds_served++;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(10, 60)) @(posedge clk_i);
      end else begin
        len = pick_gap();
        if (len > 0) begin
          out_ch.ready <= 1'b0;
          repeat (len) @(posedge clk_i);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side helpers
  // --------------------------------------------------------------------------

  // Offers one item and returns at the edge of its transfer. valid stays high
  // into the next item when there is no gap, so it is never dropped and
  // raised in the same step.
  task automatic send_item(input op_e op, input logic signed [RawW-1:0] raw);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.raw_sample <= raw;
    do @(posedge clk_i); while (!in_ch.ready);
    transfers_in++;
  endtask

  // Random readings and key events. Readings are mostly within sensor range,
  // some are whole degrees (so they land exactly on thresholds, which are
  // whole degrees for most steps) and some are any 12-bit pattern.
  task automatic send_random(input int n);
    op_e                    op;
    logic signed [RawW-1:0] raw;
    int                     r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 50) op = OP_SAMPLE;
      else if (r < 65) op = OP_MODE;
      else if (r < 82) op = OP_UP;
      else op = OP_DOWN;
      r = $urandom_range(0, 9);
      if (r < 6) raw = 12'(int'($urandom_range(0, 2880)) - 880);
      else if (r < 8) raw = 12'(16 * $urandom_range(0, 99));
      else raw = 12'($urandom());
      send_item(op, raw);
    end
  endtask

  // Stop offering, wait for every readout due, then let the pipe settle.
  // The first edge is always waited so the checker has seen the last transfer.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic write_step(input logic [StepW-1:0] v);
    step_we   <= 1'b1;
    step_data <= v;
    @(posedge clk_i);
    step_we <= 1'b0;
    step_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [StepW-1:0] step;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_SAMPLE;
    in_ch.raw_sample = '0;
    step_we          = 1'b0;
    step_data        = StepReset;
    transfers_in     = 0;
    step_writes      = 0;
    holds_requested  = 0;
    gaps_on          = 1'b1;

    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Directed, reset step of one degree.
    // Reading extremes: zero, sensor limits, full 12-bit limits, -1 and +1
    // sixteenth (rounding of both signs), alternating bit patterns.
    send_item(OP_SAMPLE, 12'sd0);
    send_item(OP_SAMPLE, 12'sd2000);
    send_item(OP_SAMPLE, -12'sd880);
    send_item(OP_SAMPLE, 12'sh7FF);
    send_item(OP_SAMPLE, 12'sh800);
    send_item(OP_SAMPLE, -12'sd1);
    send_item(OP_SAMPLE, 12'sd1);
    send_item(OP_SAMPLE, 12'sh555);
    send_item(OP_SAMPLE, 12'shAAA);
    // Alarm boundaries: exactly 30.00 and just under, exactly 10.00 and just over
    send_item(OP_SAMPLE, 12'sd480);
    send_item(OP_SAMPLE, 12'sd479);
    send_item(OP_SAMPLE, 12'sd160);
    send_item(OP_SAMPLE, 12'sd161);
    // Keys: up and down do nothing with no adjust mode, then each mode in turn
    // and the wrap back to none. The key items report the held reading again.
    send_item(OP_UP, 12'sd0);
    send_item(OP_DOWN, 12'sd0);
    send_item(OP_MODE, 12'sd0);
    send_item(OP_UP, 12'sd0);
    send_item(OP_DOWN, 12'sd0);
    send_item(OP_DOWN, 12'sd0);
    send_item(OP_MODE, 12'sd0);
    send_item(OP_UP, 12'sd0);
    send_item(OP_DOWN, 12'sd0);
    send_item(OP_MODE, 12'sd0);

    // Random phases, one step setting each. The large steps drive both
    // thresholds into saturation and across each other; a step of zero
    // freezes them.
    for (int idx = 0; idx < NumPhases; idx++) begin
      drain();
      step = (idx == NumPhases - 1) ? 10'($urandom_range(2, 999)) : PhaseSteps[idx];
      write_step(step);
      gaps_on = (idx != 2);
      if (idx == 4) begin
        // Long output hold-off while the sender keeps offering back to back:
        // the core fills and stalls its input
        holds_requested++;
        gaps_on = 1'b0;
        send_random(40);
        gaps_on = 1'b1;
      end
      send_random(PhaseItems);
    end

    drain();

    $display("Run covered %0d input transfers and %0d results over %0d step settings,",
             transfers_in, results, step_writes + 1);
    $display("including steps 0, 1, 1000 and 1023 and %0d long output hold-off(s).",
             holds_served);
    if (pending != 0) $display("%0d readouts never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
